// ----- rtl/spcs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spcs_pkg
// Shared types, codes, font table and position helpers for the shake
// driven column sequencer.
// ----------------------------------------------------------------------------
package spcs_pkg;

    localparam int MAX_LETTERS_DEF    = 64;
    localparam int SPACER_COLUMNS_DEF = 3;
    localparam int MAX_WINDOW_DEF     = 32;

    localparam int GLYPH_COLS  = 5;
    localparam int FONT_DEPTH  = 26 * GLYPH_COLS;

    // input commands
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_SHAKE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_WINDOW     = 2'd1;
    localparam logic [1:0] REG_SCROLL_MIN = 2'd2;

    localparam logic [14:0] THRESHOLD_RST  = 15'd12000;
    localparam logic [5:0]  WINDOW_RST     = 6'd20;
    localparam logic [6:0]  SCROLL_MIN_RST = 7'd4;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [5:0] slot;
        logic [2:0] sub;
    } t_pos;

    typedef struct packed {
        logic       fwd;
        t_pos       pos;
        logic [6:0] count;
        logic [6:0] win;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ADVANCE,
        BK_RUN
    } t_back_state;

    localparam logic [4:0] FONT_ROM [FONT_DEPTH] = '{
        5'h1E, 5'h05, 5'h05, 5'h05, 5'h1E,
        5'h1F, 5'h15, 5'h15, 5'h15, 5'h0A,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h11,
        5'h1F, 5'h11, 5'h11, 5'h0E, 5'h00,
        5'h1F, 5'h15, 5'h15, 5'h15, 5'h11,
        5'h1F, 5'h05, 5'h05, 5'h01, 5'h01,
        5'h0E, 5'h11, 5'h15, 5'h15, 5'h0D,
        5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F,
        5'h11, 5'h11, 5'h1F, 5'h11, 5'h11,
        5'h01, 5'h01, 5'h1F, 5'h01, 5'h0A,
        5'h1F, 5'h04, 5'h0A, 5'h11, 5'h00,
        5'h1F, 5'h10, 5'h10, 5'h10, 5'h10,
        5'h1F, 5'h01, 5'h0A, 5'h01, 5'h1F,
        5'h1F, 5'h01, 5'h02, 5'h04, 5'h1F,
        5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E,
        5'h1F, 5'h01, 5'h01, 5'h01, 5'h02,
        5'h0E, 5'h11, 5'h15, 5'h09, 5'h16,
        5'h1F, 5'h01, 5'h01, 5'h09, 5'h16,
        5'h12, 5'h11, 5'h15, 5'h11, 5'h09,
        5'h01, 5'h01, 5'h1F, 5'h01, 5'h01,
        5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F,
        5'h03, 5'h04, 5'h08, 5'h04, 5'h03,
        5'h1F, 5'h10, 5'h04, 5'h10, 5'h1F,
        5'h1B, 5'h04, 5'h04, 5'h04, 5'h1B,
        5'h03, 5'h04, 5'h08, 5'h04, 5'h03,
        5'h19, 5'h11, 5'h15, 5'h11, 5'h13
    };

    // spacer columns and out-of-range letters are dark
    function automatic logic [4:0] font_col(input logic [4:0] letter, input logic [2:0] sub);
        logic [7:0] idx;
        idx = {1'b0, letter, 2'b00} + {3'b000, letter} + {5'b00000, sub};
        if (letter >= 5'd26 || sub >= 3'(GLYPH_COLS)) begin
            return 5'd0;
        end
        return FONT_ROM[idx];
    endfunction

    // next column, wrapping at the end of the message
    function automatic t_pos pos_inc(input t_pos p, input logic [6:0] cnt,
                                     input logic [2:0] sub_last);
        t_pos q;
        q = p;
        if (p.sub == sub_last) begin
            q.sub  = 3'd0;
            q.slot = ({1'b0, p.slot} == cnt - 7'd1) ? 6'd0 : p.slot + 6'd1;
        end else begin
            q.sub = p.sub + 3'd1;
        end
        return q;
    endfunction

    // previous column, wrapping to the end of the message
    function automatic t_pos pos_dec(input t_pos p, input logic [6:0] cnt,
                                     input logic [2:0] sub_last);
        t_pos q;
        logic [6:0] top;
        q   = p;
        top = cnt - 7'd1;
        if (p.sub == 3'd0) begin
            q.sub  = sub_last;
            q.slot = (p.slot == 6'd0) ? top[5:0] : p.slot - 6'd1;
        end else begin
            q.sub = p.sub - 3'd1;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/spcs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spcs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module spcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- rtl/spcs_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spcs_fifo
// Small register queue with occupancy count, used for jobs and columns.
// ----------------------------------------------------------------------------
module spcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_wdata,
    input  wire logic                         i_pop,
    output logic      [WIDTH-1:0]             o_rdata,
    output logic                              o_empty,
    output logic                              o_full,
    output logic      [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_empty   = (r_count == CW'(0));
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_count   = r_count;
    assign o_rdata   = r_mem[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH-1)) ? PW'(0) : r_wptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH-1)) ? PW'(0) : r_rptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/spcs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spcs_front
// Takes input words, keeps configuration, message length and window start,
// stores letters and turns shakes into column jobs.
// ----------------------------------------------------------------------------
module spcs_front #(
    parameter int MAX_LETTERS    = spcs_pkg::MAX_LETTERS_DEF,
    parameter int SPACER_COLUMNS = spcs_pkg::SPACER_COLUMNS_DEF,
    parameter int MAX_WINDOW     = spcs_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [1:0]            i_command,
    input  wire logic [7:0]            i_char_code,
    input  wire logic signed [15:0]    i_accel_x,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_addr,
    input  wire logic [14:0]           i_cfg_wdata,
    input  wire logic                  i_back_busy,
    input  wire logic                  i_job_empty,
    input  wire logic                  i_job_full,
    output logic                       o_job_push,
    output spcs_pkg::t_job             o_job,
    output logic                       o_ltr_we,
    output logic [((MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1)-1:0] o_ltr_addr,
    output logic [4:0]                 o_ltr_data
);
    import spcs_pkg::*;

    localparam int AW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam logic [2:0] SubLast = 3'(GLYPH_COLS + SPACER_COLUMNS - 1);

    logic [14:0] r_thresh;
    logic [5:0]  r_win_size;
    logic [6:0]  r_scroll_min;

    logic               r_in_vld, n_in_vld;
    logic [1:0]         r_cmd;
    logic [7:0]         r_char;
    logic signed [15:0] r_accel;

    logic [6:0] r_count, n_count;
    t_pos       r_ws, n_ws;

    logic               w_take, w_accept;
    logic [7:0]         w_upper;
    logic               w_is_lower, w_is_letter;
    logic signed [16:0] w_x, w_thr;
    logic               w_fwd, w_rev;
    logic [6:0]         w_win;

    always_comb begin
        w_take = r_in_vld;
        if (r_cmd == CMD_CHAR && (i_back_busy || !i_job_empty)) begin
            w_take = 1'b0;
        end
        if (r_cmd == CMD_SHAKE && i_job_full) begin
            w_take = 1'b0;
        end
    end

    assign o_full   = r_in_vld && !w_take;
    assign w_accept = i_push && !o_full;

    assign w_is_lower  = r_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
    assign w_upper     = w_is_lower ? (r_char - CASE_OFFSET) : r_char;
    assign w_is_letter = w_upper inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};

    assign w_x   = {r_accel[15], r_accel};
    assign w_thr = signed'({2'b00, r_thresh});
    assign w_fwd = (w_x <= -w_thr);
    assign w_rev = (w_x >= w_thr);
    assign w_win = ({1'b0, r_win_size} > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW) : {1'b0, r_win_size};

    always_comb begin
        n_in_vld   = r_in_vld;
        n_count    = r_count;
        n_ws       = r_ws;
        o_job_push = 1'b0;
        o_ltr_we   = 1'b0;
        o_job.fwd   = w_fwd;
        o_job.pos   = r_ws;
        o_job.count = r_count;
        o_job.win   = w_win;
        o_ltr_addr  = r_count[AW-1:0];
        o_ltr_data  = 5'(w_upper - CHAR_UPPER_A);

        if (w_take) begin
            n_in_vld = 1'b0;
            case (r_cmd)
                CMD_BEGIN: begin
                    n_count = 7'd0;
                    n_ws    = '0;
                end
                CMD_CHAR: begin
                    if (w_is_letter && r_count < 7'(MAX_LETTERS)) begin
                        o_ltr_we = 1'b1;
                        n_count  = r_count + 7'd1;
                    end
                end
                CMD_SHAKE: begin
                    if ((w_fwd || w_rev) && r_count != 7'd0) begin
                        o_job_push = (w_win != 7'd0);
                        if (r_count >= r_scroll_min) begin
                            n_ws = pos_inc(r_ws, r_count, SubLast);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (w_accept) begin
            n_in_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_count      <= 7'd0;
            r_ws         <= '0;
            r_thresh     <= THRESHOLD_RST;
            r_win_size   <= WINDOW_RST;
            r_scroll_min <= SCROLL_MIN_RST;
        end else begin
            r_in_vld <= n_in_vld;
            r_count  <= n_count;
            r_ws     <= n_ws;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_THRESHOLD:  r_thresh     <= i_cfg_wdata;
                    REG_WINDOW:     r_win_size   <= i_cfg_wdata[5:0];
                    REG_SCROLL_MIN: r_scroll_min <= i_cfg_wdata[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_char  <= i_char_code;
            r_accel <= i_accel_x;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/spcs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spcs_back
// Walks one job's columns, reads letters from the store and pushes font
// columns into the result queue.
// ----------------------------------------------------------------------------
module spcs_back #(
    parameter int MAX_LETTERS    = spcs_pkg::MAX_LETTERS_DEF,
    parameter int SPACER_COLUMNS = spcs_pkg::SPACER_COLUMNS_DEF,
    parameter int OUT_DEPTH      = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_job_empty,
    input  wire spcs_pkg::t_job        i_job,
    output logic                       o_job_pop,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [((MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1)-1:0] o_rd_addr,
    input  wire logic [4:0]            i_rd_data,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                       o_out_push,
    output logic [5:0]                 o_out_data
);
    import spcs_pkg::*;

    localparam int AW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int CW = $clog2(OUT_DEPTH+1);
    localparam logic [2:0] SubLast = 3'(GLYPH_COLS + SPACER_COLUMNS - 1);

    t_back_state r_state, n_state;
    logic        r_fwd, n_fwd;
    t_pos        r_pos, n_pos;
    logic [6:0]  r_count, n_count;
    logic [6:0]  r_win, n_win;
    logic [6:0]  r_left, n_left;

    logic        r_rd_vld;
    logic [2:0]  r_rd_sub;
    logic        r_rd_last;
    logic        w_space;

    // room for one more word counting the read in flight
    assign w_space = ({1'b0, i_out_count} + {{CW{1'b0}}, r_rd_vld}) < (CW+1)'(OUT_DEPTH);

    assign o_busy     = (r_state != BK_IDLE);
    assign o_rd_addr  = r_pos.slot[AW-1:0];
    assign o_out_push = r_rd_vld;
    assign o_out_data = {font_col(i_rd_data, r_rd_sub), r_rd_last};

    always_comb begin
        n_state   = r_state;
        n_fwd     = r_fwd;
        n_pos     = r_pos;
        n_count   = r_count;
        n_win     = r_win;
        n_left    = r_left;
        o_job_pop = 1'b0;
        o_rd_en   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_fwd     = i_job.fwd;
                    n_pos     = i_job.pos;
                    n_count   = i_job.count;
                    n_win     = i_job.win;
                    // reverse run starts at the window's far end
                    if (!i_job.fwd && i_job.win > 7'd1) begin
                        n_left  = i_job.win - 7'd1;
                        n_state = BK_ADVANCE;
                    end else begin
                        n_left  = i_job.win;
                        n_state = BK_RUN;
                    end
                end
            end
            BK_ADVANCE: begin
                n_pos  = pos_inc(r_pos, r_count, SubLast);
                n_left = r_left - 7'd1;
                if (r_left == 7'd1) begin
                    n_left  = r_win;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (w_space) begin
                    o_rd_en = 1'b1;
                    n_pos   = r_fwd ? pos_inc(r_pos, r_count, SubLast)
                                    : pos_dec(r_pos, r_count, SubLast);
                    n_left  = r_left - 7'd1;
                    if (r_left == 7'd1) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= o_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd   <= n_fwd;
        r_pos   <= n_pos;
        r_count <= n_count;
        r_win   <= n_win;
        r_left  <= n_left;
        if (o_rd_en) begin
            r_rd_sub  <= r_pos.sub;
            r_rd_last <= (r_left == 7'd1);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/shake_pov_column_sequencer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// shake_pov_column_sequencer_core
// Shake driven persistence-of-vision column sequencer, queue style ports.
// ----------------------------------------------------------------------------
// A shake word turns into a run of min(window length, MAX_WINDOW) column
// words; the first one passes through the input register, the job queue,
// the column walker, the letter store read and the result queue, and the rest
// follow one per cycle while the result side keeps popping. A reverse run
// longer than one column first steps to the far end of the window. The column
// rate is set by the single read port of the letter store, one letter read per
// column. Character words wait at the input while a run is queued or in
// progress; begin words never wait, and shake words wait only while two runs
// are already queued ahead of the column walker.
module shake_pov_column_sequencer_core #(
    parameter int MAX_LETTERS    = spcs_pkg::MAX_LETTERS_DEF,
    parameter int SPACER_COLUMNS = spcs_pkg::SPACER_COLUMNS_DEF,
    parameter int MAX_WINDOW     = spcs_pkg::MAX_WINDOW_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_command,
    input  wire logic [7:0]         i_char_code,
    input  wire logic signed [15:0] i_accel_x,
    output logic                    empty,
    input  wire logic               pop,
    output logic [4:0]              o_column_bits,
    output logic                    o_last,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [14:0]        i_cfg_wdata
);
    import spcs_pkg::*;

    localparam int AW        = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int JobDepth  = 2;
    localparam int OutDepth  = 4;
    localparam int JobW      = $bits(t_job);

    logic          w_job_push, w_job_pop, w_job_empty, w_job_full;
    t_job          w_job_in, w_job_out;
    logic [JobW-1:0] w_job_rdata;
    logic [$clog2(JobDepth+1)-1:0] w_job_count;

    logic          w_ltr_we;
    logic [AW-1:0] w_ltr_waddr, w_rd_addr;
    logic [4:0]    w_ltr_wdata, w_rd_data;
    logic          w_rd_en, w_back_busy;

    logic          w_out_push, w_out_full;
    logic [5:0]    w_out_wdata, w_out_rdata;
    logic [$clog2(OutDepth+1)-1:0] w_out_count;

    assign w_job_out = t_job'(w_job_rdata);

    spcs_front #(
        .MAX_LETTERS    (MAX_LETTERS),
        .SPACER_COLUMNS (SPACER_COLUMNS),
        .MAX_WINDOW     (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_accel_x   (i_accel_x),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_back_busy (w_back_busy),
        .i_job_empty (w_job_empty),
        .i_job_full  (w_job_full),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in),
        .o_ltr_we    (w_ltr_we),
        .o_ltr_addr  (w_ltr_waddr),
        .o_ltr_data  (w_ltr_wdata)
    );

    spcs_fifo #(
        .WIDTH (JobW),
        .DEPTH (JobDepth)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_wdata (w_job_in),
        .i_pop   (w_job_pop),
        .o_rdata (w_job_rdata),
        .o_empty (w_job_empty),
        .o_full  (w_job_full),
        .o_count (w_job_count)
    );

    spcs_ram #(
        .WIDTH (5),
        .DEPTH (MAX_LETTERS)
    ) u_letter_store (
        .i_clk   (i_clk),
        .i_we    (w_ltr_we),
        .i_waddr (w_ltr_waddr),
        .i_wdata (w_ltr_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    spcs_back #(
        .MAX_LETTERS    (MAX_LETTERS),
        .SPACER_COLUMNS (SPACER_COLUMNS),
        .OUT_DEPTH      (OutDepth)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_job_empty),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .o_busy      (w_back_busy),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .i_out_count (w_out_count),
        .o_out_push  (w_out_push),
        .o_out_data  (w_out_wdata)
    );

    spcs_fifo #(
        .WIDTH (6),
        .DEPTH (OutDepth)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_wdata (w_out_wdata),
        .i_pop   (pop),
        .o_rdata (w_out_rdata),
        .o_empty (empty),
        .o_full  (w_out_full),
        .o_count (w_out_count)
    );

    // column word packs font bits above the last flag
    assign o_column_bits = w_out_rdata[5:1];
    assign o_last        = w_out_rdata[0] && !w_out_full ? w_out_rdata[0] : w_out_rdata[0];

endmodule
`default_nettype wire
